FILE: hw/rtl/ballistic_trajectory_stepper_macros.svh
// Assertion macros shared by the checker files of the trajectory stepper.
`ifndef BALLISTIC_TRAJECTORY_STEPPER_MACROS_SVH
`define BALLISTIC_TRAJECTORY_STEPPER_MACROS_SVH

// The consequent must hold in the clock after the antecedent.
`define BTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// The consequent must hold in the same clock as the antecedent.
`define BTS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/bts_pkg.sv
// Shared widths, codes, types and the saturation helper of the trajectory stepper.
package bts_pkg;

	// Fixed-point format of every value field.
	localparam int FRAC_BITS = 16;
	localparam int WORD_BITS = 32;

	// Derived widths: magnitude of a difference or sum, divider numerator,
	// product of a magnitude and a time value, and the wide signed accumulator.
	localparam int MAG_W  = WORD_BITS + 1;
	localparam int NUM_W  = MAG_W + FRAC_BITS;
	localparam int PROD_W = MAG_W + WORD_BITS;
	localparam int ACC_W  = 2 * WORD_BITS + 2;
	localparam int CNT_W  = $clog2(NUM_W + 1);

	// Configuration port layout.
	localparam int DATA_W   = (WORD_BITS > 32) ? 64 : 32;
	localparam int ADDR_LSB = (DATA_W == 64) ? 3 : 2;
	localparam int ADDR_W   = ADDR_LSB + 1;
	localparam logic REG_GRAVITY = 1'b0;

	// Gravity after reset is 9.81 in the chosen format.
	localparam logic [WORD_BITS-1:0] GRAVITY_RESET =
		WORD_BITS'((64'd981 << FRAC_BITS) / 64'd100);

	// Opcodes of an input request.
	localparam logic OP_INIT   = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	// Axes.
	localparam int N_AXES = 3;
	typedef logic [1:0] axis_t;
	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_Z = 2'd2;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_APPLIED,
		STAT_SKIPPED,
		STAT_REJECTED,
		STAT_SATURATED
	} stat_t;

	// Operand choice of the shared multiplier.
	typedef enum logic {
		MUL_GRAV,
		MUL_SUM
	} mul_sel_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_DIV,
		ST_INIT_WB,
		ST_VEL_WB,
		ST_AX_MUL,
		ST_AX_POS,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     take;
		logic     set_code;
		stat_t    code;
		logic     div_start;
		mul_sel_t mul_sel;
		axis_t    axis;
		logic     init_wb;
		logic     vel_wb;
		logic     pos_wb;
		logic     rem_wb;
		logic     load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic upd;
		logic zero_amt;
		logic no_step;
		logic div_done;
	} dp_stat_t;

	// Saturated word with its clip flag.
	typedef struct packed {
		logic                 clip;
		logic [WORD_BITS-1:0] val;
	} sat_t;

	// Clamp a wide signed value to the signed word range.
	function automatic sat_t sat_word(input logic signed [ACC_W-1:0] v);
		sat_t r;
		logic signed [ACC_W-1:0] hi_lim;
		logic signed [ACC_W-1:0] lo_lim;
		hi_lim = {{(ACC_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
		lo_lim = {{(ACC_W-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};
		if (v > hi_lim) begin
			r.clip = 1'b1;
			r.val  = hi_lim[WORD_BITS-1:0];
		end else if (v < lo_lim) begin
			r.clip = 1'b1;
			r.val  = lo_lim[WORD_BITS-1:0];
		end else begin
			r.clip = 1'b0;
			r.val  = v[WORD_BITS-1:0];
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/ballistic_trajectory_stepper.sv
// Ballistic trajectory stepper: a projectile's position, velocity and remaining
// flight time in signed Q16.16. One request is worked on at a time, and the
// block takes the next request while the previous result still waits at the
// output. An init request occupies the block while the restoring divider runs,
// producing one quotient bit per cycle on three lanes at once. An update request
// uses the single shared multiplier once for gravity and once per axis. A
// rejected init or a skipped update goes from the decide state straight to done.
// Gravity is written through the APB port at address 0. The user must write it
// only while the block is idle; the block itself does not enforce this.
module ballistic_trajectory_stepper import bts_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ADDR_W-1:0]           paddr,
	input  logic [DATA_W-1:0]           pwdata,
	output logic [DATA_W-1:0]           prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        opcode,
	input  logic signed [WORD_BITS-1:0] start_x,
	input  logic signed [WORD_BITS-1:0] start_y,
	input  logic signed [WORD_BITS-1:0] start_z,
	input  logic signed [WORD_BITS-1:0] target_x,
	input  logic signed [WORD_BITS-1:0] target_y,
	input  logic signed [WORD_BITS-1:0] target_z,
	input  logic [WORD_BITS-1:0]        time_amount,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [WORD_BITS-1:0] pos_x,
	output logic signed [WORD_BITS-1:0] pos_y,
	output logic signed [WORD_BITS-1:0] pos_z,
	output logic signed [WORD_BITS-1:0] vel_x,
	output logic signed [WORD_BITS-1:0] vel_y,
	output logic signed [WORD_BITS-1:0] vel_z,
	output logic [WORD_BITS-1:0]        time_left,
	output logic [1:0]                  status
);

	logic [WORD_BITS-1:0] gravity_q;
	logic                 reg_hit;
	cmd_t                 cmd;
	dp_stat_t             stat;

	// Gravity register behind the APB port.
	assign reg_hit = (paddr[ADDR_LSB] == REG_GRAVITY);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? DATA_W'(gravity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= GRAVITY_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			gravity_q <= pwdata[WORD_BITS-1:0];
		end
	end

	bts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	bts_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.gravity     (gravity_q),
		.opcode      (opcode),
		.start_x     (start_x),
		.start_y     (start_y),
		.start_z     (start_z),
		.target_x    (target_x),
		.target_y    (target_y),
		.target_z    (target_z),
		.time_amount (time_amount),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.vel_x       (vel_x),
		.vel_y       (vel_y),
		.vel_z       (vel_z),
		.time_left   (time_left),
		.status      (status)
	);

endmodule

FILE: hw/rtl/bts_div.sv
// Three-lane restoring divider with a shared divisor, one quotient bit per cycle.
module bts_div import bts_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NUM_W-1:0]     num [N_AXES],
	input  logic [WORD_BITS-1:0] den,
	output logic [NUM_W-1:0]     quo [N_AXES],
	output logic                 done
);

	logic                 busy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [WORD_BITS-1:0] den_q;
	logic [NUM_W-1:0]     num_q [N_AXES];
	logic [WORD_BITS-1:0] rem_q [N_AXES];
	logic [WORD_BITS:0]   trial [N_AXES];
	logic [WORD_BITS:0]   trial_sub [N_AXES];
	logic                 fits [N_AXES];

	// Trial subtraction of each lane.
	always_comb begin
		for (int i = 0; i < N_AXES; i++) begin
			trial[i]     = {rem_q[i], num_q[i][NUM_W-1]};
			trial_sub[i] = trial[i] - {1'b0, den_q};
			fits[i]      = trial[i] >= {1'b0, den_q};
		end
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			busy_q <= (cnt_q != CNT_W'(1));
			cnt_q  <= cnt_q - CNT_W'(1);
		end
	end

	// Numerator shifts out at the top while quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			for (int i = 0; i < N_AXES; i++) begin
				num_q[i] <= num[i];
				rem_q[i] <= '0;
			end
		end else if (busy_q) begin
			for (int i = 0; i < N_AXES; i++) begin
				num_q[i] <= {num_q[i][NUM_W-2:0], fits[i]};
				rem_q[i] <= fits[i] ? trial_sub[i][WORD_BITS-1:0] : trial[i][WORD_BITS-1:0];
			end
		end
	end

	assign quo  = num_q;
	assign done = !busy_q;

endmodule

FILE: hw/rtl/bts_dp.sv
// Datapath: trajectory state, shared multiplier, divider lanes and result register.
module bts_dp import bts_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cmd_t                        cmd,
	output dp_stat_t                    stat,
	input  logic [WORD_BITS-1:0]        gravity,
	input  logic                        opcode,
	input  logic signed [WORD_BITS-1:0] start_x,
	input  logic signed [WORD_BITS-1:0] start_y,
	input  logic signed [WORD_BITS-1:0] start_z,
	input  logic signed [WORD_BITS-1:0] target_x,
	input  logic signed [WORD_BITS-1:0] target_y,
	input  logic signed [WORD_BITS-1:0] target_z,
	input  logic [WORD_BITS-1:0]        time_amount,
	output logic signed [WORD_BITS-1:0] pos_x,
	output logic signed [WORD_BITS-1:0] pos_y,
	output logic signed [WORD_BITS-1:0] pos_z,
	output logic signed [WORD_BITS-1:0] vel_x,
	output logic signed [WORD_BITS-1:0] vel_y,
	output logic signed [WORD_BITS-1:0] vel_z,
	output logic [WORD_BITS-1:0]        time_left,
	output logic [1:0]                  status
);

	// Latched request.
	logic                        op_q;
	logic [WORD_BITS-1:0]        amt_q;
	logic signed [WORD_BITS-1:0] start_q [N_AXES];
	logic signed [WORD_BITS-1:0] target_q [N_AXES];

	// Trajectory state.
	logic signed [WORD_BITS-1:0] pos_q [N_AXES];
	logic signed [WORD_BITS-1:0] vel_q [N_AXES];
	logic [WORD_BITS-1:0]        rem_q;
	logic signed [WORD_BITS-1:0] vold_y_q;

	// Working registers.
	logic [PROD_W-1:0] prod_q;
	logic              sneg_q;
	logic              dneg_q [N_AXES];
	logic              clip_q;
	stat_t             code_q;

	// Result register.
	logic signed [WORD_BITS-1:0] out_pos_q [N_AXES];
	logic signed [WORD_BITS-1:0] out_vel_q [N_AXES];
	logic [WORD_BITS-1:0]        out_time_q;
	stat_t                       out_stat_q;

	// Combinational values.
	logic signed [MAG_W-1:0]     diff [N_AXES];
	logic                        dneg [N_AXES];
	logic [MAG_W-1:0]            dmag [N_AXES];
	logic [NUM_W-1:0]            num [N_AXES];
	logic [NUM_W-1:0]            quo [N_AXES];
	logic                        div_done;
	logic signed [WORD_BITS-1:0] v_cur;
	logic signed [WORD_BITS-1:0] v_old;
	logic signed [MAG_W-1:0]     vsum;
	logic                        sneg;
	logic [MAG_W-1:0]            smag;
	logic [MAG_W-1:0]            mul_a;
	logic signed [ACC_W-1:0]     half_prod;
	logic signed [ACC_W-1:0]     full_prod;
	logic signed [ACC_W-1:0]     qs [N_AXES];
	logic signed [ACC_W-1:0]     dr;
	sat_t                        init_v [N_AXES];
	sat_t                        vy_new;
	sat_t                        p_new;
	stat_t                       fin_stat;

	// Target minus start on each axis, in magnitude form for the divider.
	always_comb begin
		for (int i = 0; i < N_AXES; i++) begin
			diff[i] = MAG_W'(target_q[i]) - MAG_W'(start_q[i]);
			dneg[i] = diff[i][MAG_W-1];
			dmag[i] = dneg[i] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
			num[i]  = {dmag[i], {FRAC_BITS{1'b0}}};
		end
	end

	bts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num),
		.den    (amt_q),
		.quo    (quo),
		.done   (div_done)
	);

	// Old plus new velocity of the selected axis, for the position step.
	always_comb begin
		v_cur = vel_q[cmd.axis];
		v_old = (cmd.axis == AXIS_Y) ? vold_y_q : v_cur;
		vsum  = MAG_W'(v_old) + MAG_W'(v_cur);
		sneg  = vsum[MAG_W-1];
		smag  = sneg ? MAG_W'(-vsum) : MAG_W'(vsum);
		mul_a = (cmd.mul_sel == MUL_GRAV) ? {1'b0, gravity} : smag;
	end

	// Shared multiplier with its result register.
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(amt_q);
		sneg_q <= sneg;
	end

	// Write-back values for init, velocity and position steps.
	always_comb begin
		half_prod = signed'(ACC_W'(prod_q >> (FRAC_BITS + 1)));
		full_prod = signed'(ACC_W'(prod_q >> FRAC_BITS));
		for (int i = 0; i < N_AXES; i++) begin
			qs[i] = dneg_q[i] ? -signed'(ACC_W'(quo[i])) : signed'(ACC_W'(quo[i]));
		end
		init_v[0] = sat_word(qs[0]);
		init_v[1] = sat_word(qs[1] + half_prod);
		init_v[2] = sat_word(qs[2]);
		vy_new    = sat_word(ACC_W'(vel_q[1]) - full_prod);
		dr        = sneg_q ? -half_prod : half_prod;
		p_new     = sat_word(ACC_W'(pos_q[cmd.axis]) + dr);
	end

	// Latch the request, the sign of each difference and the old vertical velocity.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q     <= opcode;
			amt_q    <= time_amount;
			start_q  <= '{start_x, start_y, start_z};
			target_q <= '{target_x, target_y, target_z};
		end
		if (cmd.div_start) begin
			dneg_q <= dneg;
		end
		if (cmd.vel_wb) begin
			vold_y_q <= vel_q[1];
		end
	end

	// Trajectory state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '{default: '0};
			vel_q <= '{default: '0};
			rem_q <= '0;
		end else begin
			if (cmd.init_wb) begin
				pos_q <= start_q;
				for (int i = 0; i < N_AXES; i++) begin
					vel_q[i] <= init_v[i].val;
				end
				rem_q <= amt_q;
			end
			if (cmd.vel_wb) begin
				vel_q[1] <= vy_new.val;
			end
			if (cmd.pos_wb) begin
				pos_q[cmd.axis] <= p_new.val;
			end
			if (cmd.rem_wb) begin
				rem_q <= rem_q - amt_q;
			end
		end
	end

	// Clip flag and status code of the request in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q <= 1'b0;
			code_q <= STAT_APPLIED;
		end else if (cmd.take) begin
			clip_q <= 1'b0;
			code_q <= STAT_APPLIED;
		end else begin
			if (cmd.set_code) begin
				code_q <= cmd.code;
			end
			if (cmd.init_wb) begin
				clip_q <= init_v[0].clip | init_v[1].clip | init_v[2].clip;
			end else if (cmd.vel_wb) begin
				clip_q <= clip_q | vy_new.clip;
			end else if (cmd.pos_wb) begin
				clip_q <= clip_q | p_new.clip;
			end
		end
	end

	// Final status: an explicit code wins, else saturation is reported.
	always_comb begin
		if (code_q != STAT_APPLIED) begin
			fin_stat = code_q;
		end else if (clip_q) begin
			fin_stat = STAT_SATURATED;
		end else begin
			fin_stat = STAT_APPLIED;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_pos_q  <= pos_q;
			out_vel_q  <= vel_q;
			out_time_q <= rem_q;
			out_stat_q <= fin_stat;
		end
	end

	assign stat.upd      = (op_q == OP_UPDATE);
	assign stat.zero_amt = (amt_q == '0);
	assign stat.no_step  = (rem_q <= amt_q);
	assign stat.div_done = div_done;

	assign pos_x     = out_pos_q[0];
	assign pos_y     = out_pos_q[1];
	assign pos_z     = out_pos_q[2];
	assign vel_x     = out_vel_q[0];
	assign vel_y     = out_vel_q[1];
	assign vel_z     = out_vel_q[2];
	assign time_left = out_time_q;
	assign status    = out_stat_q;

endmodule

FILE: hw/rtl/bts_ctrl.sv
// Controller state machine: sequences init and update requests through the datapath.
module bts_ctrl import bts_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output cmd_t     cmd,
	input  dp_stat_t stat
);

	state_t state_q;
	state_t state_d;
	axis_t  ax_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!stat.upd) begin
					state_d = stat.zero_amt ? ST_DONE : ST_DIV;
				end else begin
					state_d = stat.no_step ? ST_DONE : ST_VEL_WB;
				end
			end
			ST_DIV: begin
				if (stat.div_done) begin
					state_d = ST_INIT_WB;
				end
			end
			ST_INIT_WB: state_d = ST_DONE;
			ST_VEL_WB:  state_d = ST_AX_MUL;
			ST_AX_MUL:  state_d = ST_AX_POS;
			ST_AX_POS: begin
				state_d = (ax_q == AXIS_Z) ? ST_DONE : ST_AX_MUL;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands.
	always_comb begin
		cmd         = '0;
		cmd.code    = STAT_APPLIED;
		cmd.mul_sel = MUL_GRAV;
		cmd.axis    = ax_q;
		in_stall    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
			end
			ST_DECIDE: begin
				if (!stat.upd) begin
					if (stat.zero_amt) begin
						cmd.set_code = 1'b1;
						cmd.code     = STAT_REJECTED;
					end else begin
						cmd.div_start = 1'b1;
					end
				end else if (stat.no_step) begin
					cmd.set_code = 1'b1;
					cmd.code     = STAT_SKIPPED;
				end
			end
			ST_DIV: begin
			end
			ST_INIT_WB: cmd.init_wb = 1'b1;
			ST_VEL_WB:  cmd.vel_wb = 1'b1;
			ST_AX_MUL:  cmd.mul_sel = MUL_SUM;
			ST_AX_POS: begin
				cmd.pos_wb = 1'b1;
				cmd.rem_wb = (ax_q == AXIS_Z);
			end
			ST_DONE: cmd.load_out = out_free;
			default: begin
			end
		endcase
	end

	// State, axis counter and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ax_q        <= AXIS_X;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.vel_wb) begin
				ax_q <= AXIS_X;
			end else if (cmd.pos_wb) begin
				ax_q <= ax_q + axis_t'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/bts_checker.sv
// Port-level checker of the trajectory stepper and its bind to the top level.
`include "ballistic_trajectory_stepper_macros.svh"

module bts_checker import bts_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [WORD_BITS-1:0] time_left,
	input logic [1:0]           status
);

	// A taken request keeps the block busy in the following cycle.
	`BTS_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "request taken while idle did not make the block busy")

	// A stalled result holds.
	`BTS_ASSERT_NEXT(a_result_holds, out_valid && out_stall, out_valid && $stable(status) && $stable(time_left), "stalled result changed")

	// An applied request always leaves flight time remaining.
	`BTS_ASSERT_SAME(a_applied_time_left, out_valid && (status == STAT_APPLIED || status == STAT_SATURATED), time_left != '0, "applied result shows no remaining time")

	// A new result only appears at the end of a request in flight.
	`BTS_ASSERT_SAME(a_result_from_request, $rose(out_valid), $past(in_stall), "result appeared without a request in flight")

endmodule

bind ballistic_trajectory_stepper bts_checker u_bts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.time_left (time_left),
	.status    (status)
);

FILE: bench/tb.sv
// Self-checking testbench for the ballistic trajectory stepper: random and directed flights.
`timescale 1ns / 1ps

module tb;
	import bts_pkg::*;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic signed [4*WORD_BITS-1:0] wide_t;

	// One input request and one result, with the three axes packed as arrays.
	typedef struct packed {
		logic                   op;
		word_t [N_AXES-1:0]     start;
		word_t [N_AXES-1:0]     target;
		word_t                  amt;
	} flight_req_t;

	typedef struct packed {
		word_t [N_AXES-1:0]     pos;
		word_t [N_AXES-1:0]     vel;
		word_t                  tl;
		stat_t                  st;
	} flight_state_t;

	localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t ONE_SEC  = word_t'(1) << FRAC_BITS;
	// First register index with nothing behind it.
	localparam int SPARE_REG_INDEX = 1;
	localparam logic [ADDR_W-1:0] GRAVITY_ADDR = ADDR_W'(REG_GRAVITY) << ADDR_LSB;
	localparam logic [ADDR_W-1:0] SPARE_ADDR   = ADDR_W'(SPARE_REG_INDEX) << ADDR_LSB;
	localparam int SEG_ITEMS      = 272;
	localparam int N_SEGMENTS     = 6;
	localparam int DRAIN_CYCLES   = 64;
	localparam int WATCHDOG_LIMIT = 3000;

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = OP_INIT;
	logic signed [WORD_BITS-1:0] start_x = '0, start_y = '0, start_z = '0;
	logic signed [WORD_BITS-1:0] target_x = '0, target_y = '0, target_z = '0;
	logic [WORD_BITS-1:0] time_amount = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [WORD_BITS-1:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
	logic [WORD_BITS-1:0] time_left;
	logic [1:0] status;

	ballistic_trajectory_stepper uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
		.start_x(start_x), .start_y(start_y), .start_z(start_z),
		.target_x(target_x), .target_y(target_y), .target_z(target_z),
		.time_amount(time_amount),
		.out_valid(out_valid), .out_stall(out_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
		.time_left(time_left), .status(status)
	);

	// Trajectory state as the testbench expects it, plus the gravity setting.
	// The state starts at zero, as the block does after reset.
	logic signed [WORD_BITS-1:0] pos_m [N_AXES] = '{default: '0};
	logic signed [WORD_BITS-1:0] vel_m [N_AXES] = '{default: '0};
	word_t remaining_m = '0;
	word_t grav_m = GRAVITY_RESET;
	logic clip_seen;

	flight_req_t flight_reqs[$];
	flight_state_t predicted_states[$];
	flight_req_t cur_req;

	int gap_pct;
	int stall_pct;
	int n_queued = 0;
	int n_results = 0;
	int n_mismatch = 0;
	int n_inits = 0;
	int n_updates = 0;
	int n_saturated = 0;
	int n_skipped = 0;
	int n_rejected = 0;
	int n_grav_writes = 0;
	int idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Clamp a wide value to the signed word range and note any clipping.
	function automatic logic signed [WORD_BITS-1:0] clamp_word(wide_t v);
		wide_t top;
		top = (wide_t'(1) <<< (WORD_BITS - 1)) - 1;
		if (v > top) begin
			clip_seen = 1'b1;
			return WORD_MAX;
		end
		if (v < -top - 1) begin
			clip_seen = 1'b1;
			return WORD_MIN;
		end
		return v[WORD_BITS-1:0];
	endfunction

	// Apply one request to the expected trajectory state and return the result.
	function automatic flight_state_t advance_flight(flight_req_t r);
		flight_state_t res;
		logic signed [WORD_BITS-1:0] vold [N_AXES];
		wide_t dt_w, g_w, sum, mag, dr;
		stat_t st;
		st = STAT_APPLIED;
		clip_seen = 1'b0;
		dt_w = '0;
		dt_w[WORD_BITS-1:0] = r.amt;
		g_w = '0;
		g_w[WORD_BITS-1:0] = grav_m;
		if (r.op == OP_INIT) begin
			n_inits++;
			if (r.amt == '0) begin
				st = STAT_REJECTED;
			end else begin
				// Launch velocity: distance over duration, plus g*T/2 upward.
				for (int a = 0; a < N_AXES; a++) begin
					sum = $signed(r.target[a]);
					sum = sum - $signed(r.start[a]);
					mag = (sum < 0) ? -sum : sum;
					mag = (mag <<< FRAC_BITS) / dt_w;
					if (sum < 0)
						mag = -mag;
					if (a == AXIS_Y)
						mag = mag + ((g_w * dt_w) >>> (FRAC_BITS + 1));
					vel_m[a] = clamp_word(mag);
					pos_m[a] = $signed(r.start[a]);
				end
				remaining_m = r.amt;
			end
		end else begin
			n_updates++;
			if (remaining_m <= r.amt) begin
				st = STAT_SKIPPED;
			end else begin
				for (int a = 0; a < N_AXES; a++)
					vold[a] = vel_m[a];
				sum = vold[AXIS_Y];
				vel_m[AXIS_Y] = clamp_word(sum - ((g_w * dt_w) >>> FRAC_BITS));
				// Trapezoidal step with the average of old and new velocity.
				for (int a = 0; a < N_AXES; a++) begin
					sum = vold[a];
					sum = sum + vel_m[a];
					mag = (sum < 0) ? -sum : sum;
					dr = (mag * dt_w) >>> (FRAC_BITS + 1);
					if (sum < 0)
						dr = -dr;
					sum = pos_m[a];
					pos_m[a] = clamp_word(sum + dr);
				end
				remaining_m = remaining_m - r.amt;
			end
		end
		if (st == STAT_APPLIED && clip_seen)
			st = STAT_SATURATED;
		case (st)
			STAT_SATURATED: n_saturated++;
			STAT_SKIPPED:   n_skipped++;
			STAT_REJECTED:  n_rejected++;
			default: ;
		endcase
		for (int a = 0; a < N_AXES; a++) begin
			res.pos[a] = pos_m[a];
			res.vel[a] = vel_m[a];
		end
		res.tl = remaining_m;
		res.st = st;
		return res;
	endfunction

	// Driver: presents queued requests, holding each while the block stalls.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				predicted_states.push_back(advance_flight(cur_req));
			if (!in_valid || !in_stall) begin
				if (flight_reqs.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
					cur_req = flight_reqs.pop_front();
					opcode <= cur_req.op;
					start_x <= cur_req.start[AXIS_X];
					start_y <= cur_req.start[AXIS_Y];
					start_z <= cur_req.start[AXIS_Z];
					target_x <= cur_req.target[AXIS_X];
					target_y <= cur_req.target[AXIS_Y];
					target_z <= cur_req.target[AXIS_Z];
					time_amount <= cur_req.amt;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_word(string what, int axis, word_t want, word_t got);
		if (want !== got) begin
			$display("%0t: %s[%0d] expected %h actual %h", $time, what, axis, want, got);
			n_mismatch++;
		end
	endtask

	// Monitor: compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		flight_state_t want;
		flight_state_t got;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				n_results++;
				got.pos[AXIS_X] = pos_x;
				got.pos[AXIS_Y] = pos_y;
				got.pos[AXIS_Z] = pos_z;
				got.vel[AXIS_X] = vel_x;
				got.vel[AXIS_Y] = vel_y;
				got.vel[AXIS_Z] = vel_z;
				got.tl = time_left;
				got.st = stat_t'(status);
				if (predicted_states.size() == 0) begin
					$display("%0t: result with no request pending, expected none actual pos_x %h",
						$time, pos_x);
					n_mismatch++;
				end else begin
					want = predicted_states.pop_front();
					for (int a = 0; a < N_AXES; a++) begin
						check_word("pos", a, want.pos[a], got.pos[a]);
						check_word("vel", a, want.vel[a], got.vel[a]);
					end
					check_word("time_left", 0, want.tl, got.tl);
					check_word("status", 0, word_t'(want.st), word_t'(got.st));
				end
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic void push_req(logic op, word_t sx, word_t sy, word_t sz,
			word_t tx, word_t ty, word_t tz, word_t amt);
		flight_req_t r;
		r.op = op;
		r.start[AXIS_X] = sx;
		r.start[AXIS_Y] = sy;
		r.start[AXIS_Z] = sz;
		r.target[AXIS_X] = tx;
		r.target[AXIS_Y] = ty;
		r.target[AXIS_Z] = tz;
		r.amt = amt;
		flight_reqs.push_back(r);
		n_queued++;
	endfunction

	// Coordinates: mostly within a kilometer, sometimes full range or extremes.
	function automatic word_t rand_coord();
		case ($urandom_range(0, 11))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 3))
					0: return WORD_MIN;
					1: return WORD_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return word_t'($urandom_range(0, 131072000)) - word_t'(65536000);
		endcase
	endfunction

	// Durations: mostly up to 30 seconds, sometimes zero, tiny or full range.
	function automatic word_t pick_duration();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return $urandom;
			2: return $urandom_range(1, 16);
			default: return $urandom_range(4096, 30 * 65536);
		endcase
	endfunction

	function automatic word_t pick_step(word_t dur, int steps);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return dur;
			default: return $urandom_range(0, dur / (steps + 1));
		endcase
	endfunction

	// One launch followed by a few time steps, or a single noise request.
	function automatic void queue_flight();
		word_t dur;
		int steps;
		if ($urandom_range(0, 99) < 15) begin
			push_req(1'($urandom), $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
			return;
		end
		dur = pick_duration();
		push_req(OP_INIT, rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), rand_coord(), dur);
		steps = $urandom_range(1, 8);
		for (int i = 0; i < steps; i++)
			push_req(OP_UPDATE, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, pick_step(dur, steps));
	endfunction

	// Wait until every request has gone in and every result has come out.
	task automatic wait_results();
		while (flight_reqs.size() != 0 || in_valid || predicted_states.size() != 0)
			@(negedge clk);
	endtask

	task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == GRAVITY_ADDR) begin
			grav_m = data[WORD_BITS-1:0];
			n_grav_writes++;
		end
	endtask

	task automatic check_gravity();
		logic [DATA_W-1:0] got;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= GRAVITY_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		check_word("gravity", 0, grav_m, got[WORD_BITS-1:0]);
	endtask

	initial begin
		int seg_start;
		word_t g;
		gap_pct = 12;
		stall_pct = 80;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed requests with gravity at its reset value.
		push_req(OP_UPDATE, '0, '0, '0, '0, '0, '0, '0);
		push_req(OP_INIT, '0, '0, '0, ONE_SEC, ONE_SEC, ONE_SEC, '0);
		push_req(OP_INIT, '0, '0, '0, 100 * ONE_SEC, 50 * ONE_SEC,
			word_t'(-(30 * 65536)), 5 * ONE_SEC);
		repeat (3)
			push_req(OP_UPDATE, '0, '0, '0, '0, '0, '0, ONE_SEC >> 1);
		// A step equal to the time left is skipped, as is the largest step.
		push_req(OP_UPDATE, '0, '0, '0, '0, '0, '0, 3 * ONE_SEC + (ONE_SEC >> 1));
		push_req(OP_UPDATE, '1, '1, '1, '1, '1, '1, '1);
		push_req(OP_UPDATE, '0, '0, '0, '0, '0, '0, word_t'(1));
		push_req(OP_UPDATE, '0, '0, '0, '0, '0, '0, '0);
		push_req(OP_INIT, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX,
			word_t'(1));
		push_req(OP_INIT, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MIN, '1);
		push_req(OP_INIT, '0, '0, '0, '0, '0, '0, ONE_SEC);
		// Negative quotients truncate toward zero.
		push_req(OP_INIT, '0, '0, '0, word_t'(-7), word_t'(7), word_t'(-7), word_t'(3));
		// Upward flight from the top of the range clips the height.
		push_req(OP_INIT, '0, WORD_MAX, '0, '0, WORD_MAX, '0, 10 * ONE_SEC);
		push_req(OP_UPDATE, '0, '0, '0, '0, '0, '0, word_t'(6554));
		// Clipped launch speed lets long steps drive the height to the bottom.
		push_req(OP_INIT, '0, WORD_MIN, '0, '0, WORD_MIN, '0, '1);
		push_req(OP_UPDATE, '0, '0, '0, '0, '0, '0, WORD_MIN);
		push_req(OP_UPDATE, '0, '0, '0, '0, '0, '0, WORD_MIN >> 1);
		wait_results();

		// Random flights, one gravity setting and idling pattern per segment.
		for (int seg = 0; seg < N_SEGMENTS; seg++) begin
			gap_pct = (seg < 2) ? 12 : (seg < 4) ? 80 : 0;
			stall_pct = (seg < 2) ? 80 : (seg < 4) ? 12 : 0;
			if (seg > 0) begin
				case (seg)
					1: g = '0;
					2: g = '1;
					3: g = $urandom;
					4: g = $urandom_range(1, 2000000);
					default: g = GRAVITY_RESET;
				endcase
				apb_write(GRAVITY_ADDR, DATA_W'(g));
				// A write to an unused address must leave gravity alone.
				if (seg == 3)
					apb_write(SPARE_ADDR, DATA_W'($urandom));
				check_gravity();
			end
			@(negedge clk);
			seg_start = n_queued;
			while (n_queued - seg_start < SEG_ITEMS) begin
				queue_flight();
				if ($urandom_range(0, 24) == 0)
					wait_results();
			end
			wait_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d requests (%0d launches, %0d steps) under %0d gravity writes.",
			n_queued, n_inits, n_updates, n_grav_writes);
		$display("Results: %0d saturated, %0d skipped steps, %0d rejected launches.",
			n_saturated, n_skipped, n_rejected);
		if (n_mismatch == 0 && predicted_states.size() == 0 && n_results == n_queued) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
